// ===== sv/tns_pkg.sv =====
// Shared types and constants for the top-N selection block.
// Used by the controller, the datapath and the top level.
package tns_pkg;

	localparam int DEF_MAX_KEEP      = 16;
	localparam int DEF_KEY_WIDTH     = 32;
	localparam int DEF_PAYLOAD_WIDTH = 32;

	localparam logic [1:0] STAT_ELEMENT = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_NEG     = 2'd2;

	typedef struct packed {
		logic signed [31:0] sort_key;
		logic               key_is_null;
		logic        [31:0] payload;
		logic signed [31:0] keep_count;
		logic               has_element;
		logic               last_of_array;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] out_payload;
		logic [1:0]  status;
		logic        last_result;
	} out_beat_t;

	typedef struct packed {
		logic take;
		logic pop;
	} tns_cmd_t;

	typedef struct packed {
		logic pop_done;
	} tns_stat_t;

endpackage

// ===== sv/tns_ctrl.sv =====
// Controller for the top-N selection block: load and emit phases.
// Depends on tns_pkg.
module tns_ctrl import tns_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  tns_stat_t stat,
	output tns_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = (state_q != ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign cmd.take  = in_valid && (state_q == ST_LOAD);
	assign cmd.pop   = out_valid && !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (cmd.take && in_last) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.pop && stat.pop_done) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_take_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !cmd.take) else $error("item taken while emitting");
	a_done_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && stat.pop_done) |=> !out_valid) else $error("emit did not end");
	a_last_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && in_last) |=> out_valid) else $error("emit did not start");

endmodule

// ===== sv/tns_dp.sv =====
// Datapath for the top-N selection block: a sorted list of kept entries,
// best first, with parallel compare-and-insert and shift-out. Depends on tns_pkg.
module tns_dp import tns_pkg::*; #(
	parameter int MAX_KEEP      = DEF_MAX_KEEP,
	parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
	parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tns_cmd_t  cmd,
	input  in_beat_t  in_data,
	output tns_stat_t stat,
	output out_beat_t out_data
);

	localparam int CW = $clog2(MAX_KEEP + 1);

	logic [KEY_WIDTH-1:0]     e_key_q [MAX_KEEP];
	logic                     e_null_q[MAX_KEEP];
	logic [31:0]              e_pos_q [MAX_KEEP];
	logic [PAYLOAD_WIDTH-1:0] e_pay_q [MAX_KEEP];

	logic [CW-1:0] fill_q, tgt_q;
	logic [31:0]   pos_q;
	logic          neg_q, in_array_q;
	logic [1:0]    mode_q;

	logic                     first, eff_neg, room, beats_low, do_ins, room_ins;
	logic [CW-1:0]            eff_fill, eff_tgt, sat_cnt, fill_next;
	logic [31:0]              eff_pos;
	logic [KEY_WIDTH-1:0]     new_key;
	logic [PAYLOAD_WIDTH-1:0] new_pay;
	logic [MAX_KEEP-1:0]      above;

	assign first   = !in_array_q;
	// Sign bit flipped so that unsigned order matches signed order.
	assign new_key = KEY_WIDTH'(in_data.sort_key) ^ {1'b1, {(KEY_WIDTH-1){1'b0}}};
	assign new_pay = PAYLOAD_WIDTH'(in_data.payload);
	assign sat_cnt = (in_data.keep_count[31]) ? '0 :
		(in_data.keep_count > 32'(MAX_KEEP)) ? CW'(MAX_KEEP) : CW'(in_data.keep_count);
	assign eff_fill = first ? '0 : fill_q;
	assign eff_tgt  = first ? sat_cnt : tgt_q;
	assign eff_neg  = first ? in_data.keep_count[31] : neg_q;
	assign eff_pos  = first ? '0 : pos_q;
	assign room     = eff_fill < eff_tgt;

	// Entries past the fill count act as empty slots that the new element beats.
	always_comb begin
		for (int j = 0; j < MAX_KEEP; j++) begin
			if (CW'(j) >= eff_fill) above[j] = 1'b1;
			else if (in_data.key_is_null && e_null_q[j]) above[j] = eff_pos > e_pos_q[j];
			else if (in_data.key_is_null) above[j] = 1'b0;
			else if (e_null_q[j]) above[j] = 1'b1;
			else if (new_key != e_key_q[j]) above[j] = new_key > e_key_q[j];
			else above[j] = eff_pos > e_pos_q[j];
		end
		beats_low = 1'b0;
		for (int j = 0; j < MAX_KEEP; j++) begin
			if (CW'(j + 1) == eff_fill) beats_low = above[j];
		end
	end

	assign do_ins    = cmd.take && in_data.has_element && !eff_neg && (room || beats_low);
	assign room_ins  = do_ins && room;
	assign fill_next = room_ins ? eff_fill + CW'(1) : eff_fill;

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_KEEP; j++) begin
			if (do_ins) begin
				if (above[j] && (j == 0 || !above[(j == 0) ? 0 : j - 1])) begin
					e_key_q[j]  <= new_key;
					e_null_q[j] <= in_data.key_is_null;
					e_pos_q[j]  <= eff_pos;
					e_pay_q[j]  <= new_pay;
				end else if (j > 0 && above[(j == 0) ? 0 : j - 1]) begin
					e_key_q[j]  <= e_key_q[(j == 0) ? 0 : j - 1];
					e_null_q[j] <= e_null_q[(j == 0) ? 0 : j - 1];
					e_pos_q[j]  <= e_pos_q[(j == 0) ? 0 : j - 1];
					e_pay_q[j]  <= e_pay_q[(j == 0) ? 0 : j - 1];
				end
			end else if (cmd.pop && j + 1 < MAX_KEEP) begin
				e_key_q[j]  <= e_key_q[(j + 1 < MAX_KEEP) ? j + 1 : j];
				e_null_q[j] <= e_null_q[(j + 1 < MAX_KEEP) ? j + 1 : j];
				e_pos_q[j]  <= e_pos_q[(j + 1 < MAX_KEEP) ? j + 1 : j];
				e_pay_q[j]  <= e_pay_q[(j + 1 < MAX_KEEP) ? j + 1 : j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			tgt_q      <= '0;
			pos_q      <= '0;
			neg_q      <= 1'b0;
			in_array_q <= 1'b0;
			mode_q     <= STAT_ELEMENT;
		end else if (cmd.take) begin
			in_array_q <= !in_data.last_of_array;
			tgt_q      <= eff_tgt;
			neg_q      <= eff_neg;
			fill_q     <= fill_next;
			pos_q      <= (in_data.has_element && !eff_neg) ? eff_pos + 32'd1 : eff_pos;
			if (in_data.last_of_array) begin
				if (eff_neg) mode_q <= STAT_NEG;
				else if (fill_next == '0) mode_q <= STAT_EMPTY;
				else mode_q <= STAT_ELEMENT;
			end
		end else if (cmd.pop && mode_q == STAT_ELEMENT) begin
			fill_q <= fill_q - CW'(1);
		end
	end

	assign stat.pop_done        = (mode_q != STAT_ELEMENT) || (fill_q == CW'(1));
	assign out_data.out_payload = (mode_q == STAT_ELEMENT) ? 32'(e_pay_q[0]) : '0;
	assign out_data.status      = mode_q;
	assign out_data.last_result = stat.pop_done;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_KEEP)) else $error("fill count past capacity");
	a_fill_vs_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		in_array_q |-> fill_q <= tgt_q) else $error("fill count past target");
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3) else $error("bad result mode");

endmodule

// ===== sv/top_n_select_descending.sv =====
// Top-N selection: keeps the best min(count, MAX_KEEP, length) elements of an
// array and emits their payloads in descending key order after the last beat.
// Input beats are taken while loading; the sorted list updates in parallel.
// After the last beat, results follow from the next cycle on, one per cycle
// unless out_stall holds them, up to MAX_KEEP beats, while no input is taken.
// Reset clears the control state; list entries are written before they are read.
module top_n_select_descending import tns_pkg::*; #(
	parameter int MAX_KEEP      = DEF_MAX_KEEP,
	parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
	parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	tns_cmd_t  cmd;
	tns_stat_t stat;

	tns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.last_of_array),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tns_dp #(
		.MAX_KEEP     (MAX_KEEP),
		.KEY_WIDTH    (KEY_WIDTH),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_data (in_data),
		.stat    (stat),
		.out_data(out_data)
	);

endmodule
